// File: rtl/hashed_key_open_address_table_core_assert.svh
// Assertion macros shared by the checker of the hashed key table.
`ifndef HASHED_KEY_OPEN_ADDRESS_TABLE_CORE_ASSERT_SVH
`define HASHED_KEY_OPEN_ADDRESS_TABLE_CORE_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define HKT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkt assertion failed");
// Next-cycle implication, checked outside reset.
`define HKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkt assertion failed");
`endif

// File: rtl/hkt_pkg.sv
// Shared types and constants of the hashed key table.
package hkt_pkg;
  localparam logic [31:0] FNV_PRIME    = 32'd16777619;
  localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
  localparam logic [31:0] HASH_EMPTY   = 32'h0000_0000;
  localparam logic [31:0] HASH_DELETED = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // Operation handed from the hashing front to the table back.
  typedef struct packed {
    req_t        req;
    logic [31:0] hash;
  } op_t;
endpackage

// File: rtl/hkt_queue.sv
// Two-entry queue between the hashing front and the table back.
module hkt_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/hkt_front.sv
// Hashing front: folds key bytes into FNV-1a and queues finished operations.
module hkt_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             req_type,
  input  logic [7:0]             key_byte,
  input  logic                   key_last,
  input  logic [VALUE_WIDTH-1:0] value_in,
  input  logic                   hold,
  input  logic                   q_full,
  output logic                   q_push,
  output hkt_pkg::op_t           q_op,
  output logic [VALUE_WIDTH-1:0] q_value
);
  import hkt_pkg::*;

  logic [31:0] running_hash;
  logic [31:0] product;
  logic        accept;

  assign product  = (running_hash ^ {24'd0, key_byte}) * FNV_PRIME;
  assign in_stall = hold || (key_last && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && key_last;
  assign q_value  = value_in;

  always_comb begin
    q_op.req = req_t'(req_type);
    if (product == HASH_EMPTY) begin
      q_op.hash = 32'd1;
    end else if (product == HASH_DELETED) begin
      q_op.hash = HASH_DELETED - 32'd1;
    end else begin
      q_op.hash = product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (accept) begin
      running_hash <= key_last ? FNV_BASIS : product;
    end
  end
endmodule

// File: rtl/hkt_back.sv
// Table back: remainders, probing of the bucket store, clears and results.
module hkt_back #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [10:0]            table_size,
  input  logic                   q_empty,
  input  hkt_pkg::op_t           q_op,
  input  logic [VALUE_WIDTH-1:0] q_value,
  output logic                   q_pop,
  output logic                   init_busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] value_out,
  output logic [10:0]            entry_count
);
  import hkt_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_CHK, S_FIN, S_CLEAR} state_t;

  state_t                 state;
  op_t                    op;
  logic [VALUE_WIDTH-1:0] op_value;
  logic [SW-1:0]          size;
  logic [SW-1:0]          rem1;
  logic [SW-1:0]          rem2;
  logic [SW:0]            t1;
  logic [SW:0]            t2;
  logic [SW:0]            t1_next;
  logic [SW:0]            t2_next;
  logic [4:0]             bit_idx;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          step;
  logic [SW-1:0]          probes;
  logic                   free_found;
  logic [IW-1:0]          free_slot;
  logic [IW-1:0]          clr_cnt;
  logic                   init_pass;
  logic [SW-1:0]          used_count;
  logic                   fin_hwe;
  logic                   fin_vwe;
  logic [IW-1:0]          fin_addr;
  logic [31:0]            fin_hash;
  logic [1:0]             fin_status;
  logic [VALUE_WIDTH-1:0] fin_value;
  logic [SW-1:0]          fin_used;
  logic                   out_free;

  logic [31:0]            bucket_hash  [DEPTH];
  logic [VALUE_WIDTH-1:0] bucket_value [DEPTH];
  logic [31:0]            rd_hash;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   hash_we;
  logic [IW-1:0]          hash_waddr;
  logic [31:0]            hash_wdata;
  logic                   value_we;

  logic                   slot_free;
  logic                   free_found_next;
  logic [IW-1:0]          free_slot_next;
  logic                   probe_last;
  logic [IW:0]            idx_sum;
  logic [IW:0]            step_sum;
  logic [IW-1:0]          idx_adv;
  logic [IW-1:0]          step_adv;

  logic                   chk_done;
  logic                   fin_hwe_next;
  logic                   fin_vwe_next;
  logic [IW-1:0]          fin_addr_next;
  logic [31:0]            fin_hash_next;
  logic [1:0]             fin_status_next;
  logic [VALUE_WIDTH-1:0] fin_value_next;
  logic [SW-1:0]          fin_used_next;

  always_comb begin
    if (32'(table_size) < 32'd2) begin
      size = SW'(2);
    end else if (32'(table_size) > 32'(DEPTH)) begin
      size = SW'(DEPTH);
    end else begin
      size = SW'(table_size);
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign init_busy = init_pass;
  assign q_pop     = (state == S_IDLE) && !q_empty;

  // One bit of each remainder per cycle.
  assign t1      = {rem1, op.hash[bit_idx]};
  assign t2      = {rem2, op.hash[bit_idx]};
  assign t1_next = (t1 >= {1'b0, size}) ? t1 - {1'b0, size} : t1;
  assign t2_next = (t2 >= {1'b0, size - SW'(1)}) ? t2 - {1'b0, size - SW'(1)} : t2;

  always_comb begin
    slot_free       = (rd_hash == HASH_EMPTY) || (rd_hash == HASH_DELETED);
    free_found_next = free_found || slot_free;
    free_slot_next  = (!free_found && slot_free) ? idx : free_slot;
    probe_last      = (probes + SW'(1)) == size;
    idx_sum         = {1'b0, idx} + {1'b0, step};
    idx_adv         = (idx_sum >= (IW+1)'(size)) ? IW'(idx_sum - (IW+1)'(size))
                                                 : IW'(idx_sum);
    step_sum        = {1'b0, step} + (IW+1)'(1);
    step_adv        = (step_sum >= (IW+1)'(size)) ? IW'(1) : IW'(step_sum);
  end

  // Outcome of the current probe: a hit, an empty slot or the last probe
  // ends the search.
  always_comb begin
    chk_done        = 1'b1;
    fin_hwe_next    = 1'b0;
    fin_vwe_next    = 1'b0;
    fin_value_next  = '0;
    fin_status_next = ST_OK;
    fin_used_next   = used_count;
    fin_addr_next   = idx;
    fin_hash_next   = op.hash;
    if (rd_hash == op.hash) begin
      case (op.req)
        REQ_INSERT: fin_vwe_next = 1'b1;
        REQ_LOOKUP: fin_value_next = rd_value;
        REQ_REMOVE: begin
          fin_hwe_next  = 1'b1;
          fin_hash_next = HASH_DELETED;
          if (used_count != '0) fin_used_next = used_count - SW'(1);
        end
        default: ;
      endcase
    end else if ((rd_hash == HASH_EMPTY) || probe_last) begin
      if (op.req == REQ_INSERT) begin
        if ((used_count >= size) || !free_found_next) begin
          fin_status_next = ST_FULL;
        end else begin
          fin_hwe_next  = 1'b1;
          fin_vwe_next  = 1'b1;
          fin_addr_next = free_slot_next;
          fin_used_next = used_count + SW'(1);
        end
      end else begin
        fin_status_next = ST_MISSING;
      end
    end else begin
      chk_done = 1'b0;
    end
  end

  always_comb begin
    hash_we    = (state == S_CLEAR) || ((state == S_FIN) && out_free && fin_hwe);
    hash_waddr = (state == S_CLEAR) ? clr_cnt : fin_addr;
    hash_wdata = (state == S_CLEAR) ? HASH_EMPTY : fin_hash;
    value_we   = (state == S_FIN) && out_free && fin_vwe;
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      bucket_hash[hash_waddr] <= hash_wdata;
    end
    rd_hash <= bucket_hash[idx];
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      bucket_value[fin_addr] <= op_value;
    end
    rd_value <= bucket_value[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      init_pass  <= 1'b1;
      clr_cnt    <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op       <= q_op;
            op_value <= q_value;
            rem1     <= '0;
            rem2     <= '0;
            bit_idx  <= 5'd31;
            clr_cnt  <= '0;
            state    <= (q_op.req == REQ_CLEAR) ? S_CLEAR : S_DIV;
          end
        end
        S_DIV: begin
          rem1    <= SW'(t1_next);
          rem2    <= SW'(t2_next);
          bit_idx <= bit_idx - 5'd1;
          if (bit_idx == 5'd0) begin
            idx        <= IW'(SW'(t1_next));
            step       <= (SW'(t2_next) == '0) ? IW'(1) : IW'(SW'(t2_next));
            probes     <= '0;
            free_found <= 1'b0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (chk_done) begin
            fin_hwe    <= fin_hwe_next;
            fin_vwe    <= fin_vwe_next;
            fin_value  <= fin_value_next;
            fin_status <= fin_status_next;
            fin_used   <= fin_used_next;
            fin_addr   <= fin_addr_next;
            fin_hash   <= fin_hash_next;
            state      <= S_FIN;
          end else begin
            free_found <= free_found_next;
            free_slot  <= free_slot_next;
            idx        <= idx_adv;
            step       <= step_adv;
            probes     <= probes + SW'(1);
            state      <= S_RD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= fin_status;
            value_out   <= fin_value;
            entry_count <= 11'(fin_used);
            used_count  <= fin_used;
            state       <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == IW'(DEPTH - 1)) begin
            init_pass  <= 1'b0;
            if (init_pass) begin
              state <= S_IDLE;
            end else begin
              fin_hwe    <= 1'b0;
              fin_vwe    <= 1'b0;
              fin_status <= ST_OK;
              fin_value  <= '0;
              fin_used   <= '0;
              state      <= S_FIN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/hashed_key_open_address_table_core.sv
// Top level of the hashed key open-address table.
//
// Usage: key bytes arrive on the input channel (in_valid/in_stall), one
// item per byte. Each byte is folded into a running FNV-1a hash, so
// non-final bytes are taken back to back. The item marked by
// key_last carries the request and value; its finished hash goes into a
// two-entry queue and the key hash restarts at the offset basis.
// The back end takes queued operations one at a time: it forms the two
// remainders bit-serially, then each probe is a registered store read
// followed by a compare, and a finish step writes the store and sends
// the result. A clear sweeps every bucket, one per cycle.
// Exactly one result item leaves the output register per final byte.
// After reset the whole store is swept, and in_stall stays high during
// that pass. A stalled result holds in the output register; the back
// end waits, and the queue then fills and stalls final bytes.
// The table_size register is written over cfg_valid/cfg_ready; the user
// must write it only while the block is idle, as the block itself does
// not enforce this; cfg_ready is always high.
module hashed_key_open_address_table_core #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [10:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             req_type,
  input  logic [7:0]             key_byte,
  input  logic                   key_last,
  input  logic [VALUE_WIDTH-1:0] value_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] value_out,
  output logic [10:0]            entry_count
);
  import hkt_pkg::*;

  localparam int QW = $bits(op_t) + VALUE_WIDTH;

  logic [10:0]            table_size;
  logic                   q_push;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  op_t                    push_op;
  logic [VALUE_WIDTH-1:0] push_value;
  logic [QW-1:0]          pop_data;
  logic                   init_busy;

  // The size register is always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  hkt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .key_byte (key_byte),
    .key_last (key_last),
    .value_in (value_in),
    .hold     (init_busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op),
    .q_value  (push_value)
  );

  hkt_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_op, push_value}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  hkt_back #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .table_size  (table_size),
    .q_empty     (q_empty),
    .q_op        (op_t'(pop_data[QW-1:VALUE_WIDTH])),
    .q_value     (pop_data[VALUE_WIDTH-1:0]),
    .q_pop       (q_pop),
    .init_busy   (init_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count)
  );
endmodule

// File: rtl/hkt_checker.sv
// Port-level checker of the hashed key table, bound to the top level.
`include "hashed_key_open_address_table_core_assert.svh"
module hkt_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             status,
  input logic [VALUE_WIDTH-1:0] value_out,
  input logic [10:0]            entry_count
);
  import hkt_pkg::*;

  `HKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `HKT_ASSERT_NOW(a_status_code, out_valid, (status == ST_OK) || (status == ST_FULL) || (status == ST_MISSING))
  `HKT_ASSERT_NOW(a_value_zero, out_valid && (status != ST_OK), value_out == '0)
  `HKT_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL), entry_count != 11'd0)
endmodule

bind hashed_key_open_address_table_core hkt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_chk (.*);

// File: tb/hashed_key_open_address_table_core_tb.sv
// Self-checking testbench of the hashed key open-address table core.
module hashed_key_open_address_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hkt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LONG_HOLD = 300;

  // One result item as the block should report it.
  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [10:0] count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_INSERT;
  logic [7:0]  key_byte = '0;
  logic        key_last = 1'b0;
  logic [31:0] value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [10:0] entry_count;

  hashed_key_open_address_table_core #(.DEPTH(DEPTH), .VALUE_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .key_byte(key_byte), .key_last(key_last),
    .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .value_out(value_out), .entry_count(entry_count)
  );

  always #4 clk = ~clk;

  // Shadow copy of the table, kept in step with every accepted item.
  logic [31:0]  shadow_hash [DEPTH];
  logic [31:0]  shadow_value [DEPTH];
  logic [31:0]  key_hash_acc = FNV_BASIS;
  int unsigned  shadow_count = 0;
  logic [10:0]  size_reg = 11'd1024;

  table_result_t pending_results[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  size_settings = 0;
  bit  quiet = 1'b0;

  // Receiver side: random stall bursts, plus a long hold-off on request.
  bit hold_tgl = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      burst_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result item is compared with the oldest expectation.
  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: status %0d value %h count %0d",
                   $realtime, status, value_out, entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || value_out !== exp_r.value
            || entry_count !== exp_r.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status %0d value %h count %0d, got %0d %h %0d",
                     $realtime, exp_r.status, exp_r.value, exp_r.count,
                     status, value_out, entry_count);
        end
      end
    end
  end

  function automatic int unsigned active_size();
    if (size_reg < 2) return 2;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  // Walks the probe sequence of hash h. hit is the matching slot or -1;
  // free_at is the first empty or deleted slot passed, or -1.
  function automatic void probe_chain(input logic [31:0] h, output int hit,
                                      output int free_at);
    int unsigned sz, idx, step;
    sz = active_size();
    idx = h % sz;
    step = h % (sz - 1);
    hit = -1;
    free_at = -1;
    if (step == 0) step = 1;
    for (int unsigned n = 0; n < sz; n++) begin
      if (shadow_hash[idx] == h) begin
        hit = idx;
        return;
      end
      if (shadow_hash[idx] == HASH_EMPTY || shadow_hash[idx] == HASH_DELETED) begin
        if (free_at < 0) free_at = idx;
        if (shadow_hash[idx] == HASH_EMPTY) return;
      end
      idx += step;
      if (idx >= sz) idx -= sz;
      step++;
      if (step >= sz) step = 1;
    end
  endfunction

  // Folds one accepted key byte in; on the final byte runs the request on
  // the shadow table and queues the result it should produce.
  function automatic void table_apply(req_t r, logic [7:0] b, bit last,
                                      logic [31:0] v);
    logic [31:0] h;
    table_result_t res;
    int hit, free_at;
    key_hash_acc = (key_hash_acc ^ {24'd0, b}) * FNV_PRIME;
    if (!last) return;
    h = key_hash_acc;
    if (h == HASH_EMPTY) h = 32'd1;
    else if (h == HASH_DELETED) h = HASH_DELETED - 1;
    key_hash_acc = FNV_BASIS;
    res.status = ST_OK;
    res.value = '0;
    case (r)
      REQ_INSERT: begin
        probe_chain(h, hit, free_at);
        if (hit >= 0) begin
          shadow_value[hit] = v;
        end else if (shadow_count >= active_size() || free_at < 0) begin
          res.status = ST_FULL;
        end else begin
          shadow_hash[free_at] = h;
          shadow_value[free_at] = v;
          shadow_count++;
        end
      end
      REQ_LOOKUP: begin
        probe_chain(h, hit, free_at);
        if (hit >= 0) res.value = shadow_value[hit];
        else res.status = ST_MISSING;
      end
      REQ_REMOVE: begin
        probe_chain(h, hit, free_at);
        if (hit >= 0) begin
          shadow_hash[hit] = HASH_DELETED;
          if (shadow_count > 0) shadow_count--;
        end else begin
          res.status = ST_MISSING;
        end
      end
      default: begin
        foreach (shadow_hash[i]) shadow_hash[i] = HASH_EMPTY;
        shadow_count = 0;
      end
    endcase
    res.count = shadow_count[10:0];
    pending_results.push_back(res);
  endfunction

  // Offers one key byte and waits until the block takes it. valid stays
  // high afterwards so that a following item goes out back to back;
  // anything that lets time pass lowers it first.
  task automatic send_byte(req_t r, logic [7:0] b, bit last, logic [31:0] v);
    in_valid <= 1'b1;
    req_type <= r;
    key_byte <= b;
    key_last <= last;
    value_in <= v;
    do @(posedge clk); while (in_stall);
    table_apply(r, b, last, v);
    items_sent++;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Sends a whole key; the request field only matters on the last byte.
  task automatic send_key(req_t r, logic [39:0] kb, int len, logic [31:0] v);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) send_byte(r, kb[8*i +: 8], 1'b1, v);
      else send_byte(req_t'($urandom_range(0, 3)), kb[8*i +: 8], 1'b0, $urandom);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_size(logic [10:0] sz);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= sz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = sz;
    size_settings++;
  endtask

  // Finds a five-byte key whose raw hash is the target, by meeting in the
  // middle: three bytes forward from the basis, two bytes back from the end.
  function automatic logic [39:0] key_for_hash(logic [31:0] target);
    logic [23:0] fwd [logic [31:0]];
    logic [31:0] inv, s, u, back;
    inv = FNV_PRIME;
    repeat (5) inv = inv * (32'd2 - FNV_PRIME * inv);
    for (int p = 0; p < 4; p++)
      for (int b1 = 0; b1 < 256; b1++)
        for (int b2 = 0; b2 < 256; b2++) begin
          s = ((FNV_BASIS ^ p) * FNV_PRIME);
          s = ((s ^ b1) * FNV_PRIME);
          s = ((s ^ b2) * FNV_PRIME);
          fwd[s] = {b2[7:0], b1[7:0], p[7:0]};
        end
    u = target * inv;
    for (int b4 = 0; b4 < 256; b4++) begin
      back = (u ^ b4) * inv;
      for (int b3 = 0; b3 < 256; b3++)
        if (fwd.exists(back ^ b3))
          return {b4[7:0], b3[7:0], fwd[back ^ b3]};
    end
    $display("no key found for hash %h, using a plain key", target);
    return 40'h0102030405;
  endfunction

  // Insert, overwrite, lookup hit and miss, remove hit and miss, tombstone.
  task automatic test_basic_ops();
    send_key(REQ_INSERT, 40'h61, 1, 32'hFFFF_FFFF);
    send_key(REQ_LOOKUP, 40'h61, 1, 32'h0);
    send_key(REQ_INSERT, 40'h61, 1, 32'h0000_0000);
    send_key(REQ_LOOKUP, 40'h61, 1, 32'hA5A5_A5A5);
    send_key(REQ_INSERT, 40'hFF00, 2, 32'h1234_5678);
    send_key(REQ_LOOKUP, 40'h62, 1, 32'h0);
    send_key(REQ_REMOVE, 40'h62, 1, 32'h0);
    send_key(REQ_REMOVE, 40'h61, 1, 32'h0);
    send_key(REQ_LOOKUP, 40'h61, 1, 32'h0);
    send_key(REQ_LOOKUP, 40'hFF00, 2, 32'h0);
  endtask

  // Keys whose hashes land on the empty and deleted markers are remapped.
  task automatic test_marker_hashes();
    logic [39:0] zero_key, ones_key;
    zero_key = key_for_hash(HASH_EMPTY);
    ones_key = key_for_hash(HASH_DELETED);
    send_key(REQ_INSERT, zero_key, 5, 32'h0BAD_F00D);
    send_key(REQ_INSERT, ones_key, 5, 32'hC0DE_0001);
    send_key(REQ_LOOKUP, zero_key, 5, 32'h0);
    send_key(REQ_LOOKUP, ones_key, 5, 32'h0);
    send_key(REQ_CLEAR, 40'hFFFF, 2, 32'h0);
    send_key(REQ_LOOKUP, zero_key, 5, 32'h0);
  endtask

  // Sizes below two and above the store depth; a full table rejects.
  task automatic test_size_limits();
    write_size(11'd0);
    send_key(REQ_CLEAR, 40'h0, 1, 32'h0);
    send_key(REQ_INSERT, 40'h31, 1, 32'h11);
    send_key(REQ_INSERT, 40'h32, 1, 32'h22);
    send_key(REQ_INSERT, 40'h33, 1, 32'h33);
    send_key(REQ_INSERT, 40'h31, 1, 32'h44);
    send_key(REQ_LOOKUP, 40'h31, 1, 32'h0);
    write_size(11'd2047);
    send_key(REQ_INSERT, 40'h33, 1, 32'h55);
    send_key(REQ_LOOKUP, 40'h33, 1, 32'h0);
  endtask

  // The receiver holds off for a long time while items keep coming, so the
  // queue fills and the input stalls. Then the sender waits for all results.
  task automatic test_backpressure();
    write_size(11'd64);
    hold_tgl <= ~hold_tgl;
    for (int i = 0; i < 12; i++)
      send_key(req_t'($urandom_range(0, 1)), {32'd0, 8'(i)}, 1, $urandom);
    drain();
  endtask

  // Random requests on a small key pool, so hits, misses and tombstones turn up,
  // and at sizes below the pool size a full table as well.
  task automatic test_random(logic [10:0] sz, int n_items);
    logic [39:0] pool [24];
    int pool_len [24];
    int n_keys, k, stop_at, pick;
    req_t r;
    write_size(sz);
    n_keys = (sz + 4 < 24) ? sz + 4 : 24;
    for (int i = 0; i < n_keys; i++) begin
      pool[i] = 40'({$urandom, $urandom});
      pool_len[i] = $urandom_range(1, 4);
    end
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      k = $urandom_range(0, n_keys - 1);
      pick = $urandom_range(0, 99);
      if (pick < 40) r = REQ_INSERT;
      else if (pick < 72) r = REQ_LOOKUP;
      else if (pick < 97) r = REQ_REMOVE;
      else r = REQ_CLEAR;
      if ($urandom_range(0, 9) == 0)
        send_key(r, 40'({$urandom, $urandom}), $urandom_range(1, 5), $urandom);
      else
        send_key(r, pool[k], pool_len[k], $urandom);
    end
  endtask

  initial begin
    foreach (shadow_hash[i]) begin
      shadow_hash[i] = HASH_EMPTY;
      shadow_value[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_marker_hashes();
    test_size_limits();
    test_backpressure();
    test_random(11'd3, 150);
    test_random(11'd7, 150);
    test_random(11'd16, 150);
    test_random(11'd1024, 150);
    test_random(11'd2, 120);
    test_random(11'd37, 150);
    quiet = 1'b1;
    test_random(11'd11, 120);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d key bytes, %0d results, %0d table sizes.",
             items_sent, results_seen, size_settings);
    $display("Insert, lookup, remove, clear, marker hashes and full tables checked.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in all", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #100ms;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
